@@ hdl/s16df_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s16df_pkg: shared types and constants of the sum16 packet deframer
// Frame constants, result codes and the result struct that the parser
// hands to the top level.
// ----------------------------------------------------------------------------
package s16df_pkg;

  localparam logic [7:0]  HDR_HI     = 8'hEF;
  localparam logic [7:0]  HDR_LO     = 8'h01;
  localparam logic [7:0]  ID_DATA    = 8'h02;
  localparam logic [7:0]  ID_ACK     = 8'h07;
  localparam logic [7:0]  ID_END     = 8'h08;
  localparam logic [31:0] ADDR_RESET = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_GOOD  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_HEADER   = 3'd1,
    ERR_ADDRESS  = 3'd2,
    ERR_ID       = 3'd3,
    ERR_LENGTH   = 3'd4,
    ERR_CHECKSUM = 3'd5
  } err_t;

  typedef struct packed {
    logic        vld;
    kind_t       kind;
    logic [7:0]  data;
    logic [7:0]  id;
    logic [15:0] len;
    err_t        err;
  } s16df_res_t;

endpackage

@@ hdl/s16df_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s16df_parser: frame parser of the sum16 packet deframer
// Holds the parse state and decides, for each item, the next state and
// the result, if any, that the item causes.
// ----------------------------------------------------------------------------
module s16df_parser
  import s16df_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [7:0]  rx_byte,
  input  logic [31:0] dev_addr,
  output s16df_res_t  res
);

  typedef enum logic [3:0] {
    PH_HDR0  = 4'd0,
    PH_HDR1  = 4'd1,
    PH_ADDR0 = 4'd2,
    PH_ADDR1 = 4'd3,
    PH_ADDR2 = 4'd4,
    PH_ADDR3 = 4'd5,
    PH_ID    = 4'd6,
    PH_LENHI = 4'd7,
    PH_LENLO = 4'd8,
    PH_DATA  = 4'd9,
    PH_CKHI  = 4'd10,
    PH_CKLO  = 4'd11
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [15:0] left_r, left_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [7:0]  hi_r, hi_nxt;
  logic [15:0] len_r, len_nxt;

  logic [7:0]  want;
  logic [15:0] word;
  logic [15:0] sum_add;
  logic [15:0] left_dec;
  logic [15:0] len_m2;

  assign word     = {hi_r, rx_byte};
  assign sum_add  = sum_r + {8'd0, rx_byte};
  assign left_dec = left_r - 16'd1;
  assign len_m2   = word - 16'd2;

  always_comb begin
    unique case (phase_r)
      PH_ADDR0: want = dev_addr[31:24];
      PH_ADDR1: want = dev_addr[23:16];
      PH_ADDR2: want = dev_addr[15:8];
      default:  want = dev_addr[7:0];
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    sum_nxt   = sum_r;
    left_nxt  = left_r;
    id_nxt    = id_r;
    hi_nxt    = hi_r;
    len_nxt   = len_r;
    res.vld   = 1'b0;
    res.kind  = KIND_ERROR;
    res.data  = 8'd0;
    res.err   = ERR_NONE;

    unique case (phase_r)
      PH_HDR0: begin
        if (rx_byte != HDR_HI) begin
          res.vld = 1'b1;
          res.err = ERR_HEADER;
        end else begin
          id_nxt    = 8'd0;
          len_nxt   = 16'd0;
          sum_nxt   = 16'd0;
          left_nxt  = 16'd0;
          phase_nxt = PH_HDR1;
        end
      end
      PH_HDR1: begin
        if (rx_byte != HDR_LO) begin
          res.vld   = 1'b1;
          res.err   = ERR_HEADER;
          phase_nxt = PH_HDR0;
        end else begin
          phase_nxt = PH_ADDR0;
        end
      end
      PH_ADDR0, PH_ADDR1, PH_ADDR2, PH_ADDR3: begin
        if (rx_byte != want) begin
          res.vld   = 1'b1;
          res.err   = ERR_ADDRESS;
          phase_nxt = PH_HDR0;
        end else begin
          phase_nxt = phase_t'(phase_r + 4'd1);
        end
      end
      PH_ID: begin
        id_nxt = rx_byte;
        if (rx_byte != ID_DATA && rx_byte != ID_ACK && rx_byte != ID_END) begin
          res.vld   = 1'b1;
          res.err   = ERR_ID;
          phase_nxt = PH_HDR0;
        end else begin
          sum_nxt   = sum_add;
          phase_nxt = PH_LENHI;
        end
      end
      PH_LENHI: begin
        hi_nxt    = rx_byte;
        sum_nxt   = sum_add;
        phase_nxt = PH_LENLO;
      end
      PH_LENLO: begin
        sum_nxt = sum_add;
        if (word[15:1] == 15'd0) begin
          res.vld   = 1'b1;
          res.err   = ERR_LENGTH;
          phase_nxt = PH_HDR0;
        end else begin
          len_nxt   = len_m2;
          left_nxt  = len_m2;
          phase_nxt = (len_m2 == 16'd0) ? PH_CKHI : PH_DATA;
        end
      end
      PH_DATA: begin
        sum_nxt  = sum_add;
        left_nxt = left_dec;
        if (left_dec == 16'd0) begin
          phase_nxt = PH_CKHI;
        end
        res.vld  = 1'b1;
        res.kind = KIND_DATA;
        res.data = rx_byte;
      end
      PH_CKHI: begin
        hi_nxt    = rx_byte;
        phase_nxt = PH_CKLO;
      end
      PH_CKLO: begin
        res.vld   = 1'b1;
        phase_nxt = PH_HDR0;
        if (word != sum_r) begin
          res.err = ERR_CHECKSUM;
        end else begin
          res.kind = KIND_GOOD;
        end
      end
      default: begin
        phase_nxt = PH_HDR0;
      end
    endcase

    res.id  = id_nxt;
    res.len = len_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR0;
      sum_r   <= 16'd0;
      left_r  <= 16'd0;
      id_r    <= 8'd0;
      hi_r    <= 8'd0;
      len_r   <= 16'd0;
    end else if (step) begin
      phase_r <= phase_nxt;
      sum_r   <= sum_nxt;
      left_r  <= left_nxt;
      id_r    <= id_nxt;
      hi_r    <= hi_nxt;
      len_r   <= len_nxt;
    end
  end

endmodule

@@ hdl/sum16_packet_deframer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sum16_packet_deframer_top: receive deframer for sum16 checksummed packets
// Input register, frame parser and result register with valid/ready on
// each side and a one-register configuration port.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle, with no gaps, while the result side
// keeps up. A byte is held in the input register, parsed by compare and
// 16-bit add logic that also updates the parse state, and a result, when
// the byte causes one, lands in the result register, which drives
// out_valid. A byte that causes no result still
// waits in the input register while the result register is full and not
// being taken. Header bytes EF 01 and the four address bytes (most
// significant first, from cfg_data) are checked, then the id, the
// big-endian length, the payload bytes (passed out one per result) and
// the big-endian sum16 checksum. Every error returns the parser to header
// hunting. Write cfg_data only while no item is in flight.
module sum16_packet_deframer_top
  import s16df_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_payload_byte,
  output logic [7:0]  out_packet_id,
  output logic [15:0] out_payload_length,
  output logic [2:0]  out_error_code,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  logic [31:0] addr_r;
  logic        byte_vld_r;
  logic [7:0]  byte_r;
  logic        out_vld_r;
  s16df_res_t  out_r;
  s16df_res_t  res;
  logic        step;

  assign cfg_ready = 1'b1;
  assign step      = byte_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !byte_vld_r || step;

  s16df_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .rx_byte  (byte_r),
    .dev_addr (addr_r),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r     <= ADDR_RESET;
      byte_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        addr_r <= cfg_data;
      end
      if (in_ready) begin
        byte_vld_r <= in_valid;
      end
      if (step && res.vld) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_rx_byte;
    end
    if (step && res.vld) begin
      out_r <= res;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_kind           = out_r.kind;
  assign out_payload_byte   = out_r.data;
  assign out_packet_id      = out_r.id;
  assign out_payload_length = out_r.len;
  assign out_error_code     = out_r.err;

  a_data_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_DATA |-> out_error_code == ERR_NONE)
    else $error("payload result carries an error code");

  a_err_has_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_ERROR |-> out_error_code != ERR_NONE)
    else $error("error result without an error code");

  a_byte_only_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_DATA |-> out_payload_byte == 8'd0)
    else $error("payload byte set on a non-payload result");

  a_step_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.vld && out_vld_r |-> out_ready)
    else $error("result overwrites one not yet taken");

endmodule
